@@ rtl/gcpm_pkg.sv @@
// Shared types and constants for the grid cell point mean map.
// Used by every module of the block; depends on nothing else.
package gcpm_pkg;

  localparam int GRID_X    = 256;
  localparam int GRID_Y    = 256;
  localparam int NCELLS    = GRID_X * GRID_Y;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DIV_STEPS = 33;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 8;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SCAN = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 8'd3;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SCAN = 2'd1,
    OP_READ = 2'd2,
    OP_NULL = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
  } cmd_t;

  typedef struct packed {
    logic               in_range;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [15:0]        point_count;
    logic               stable;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [15:0]        count;
    logic               prev;
    logic               cur;
  } cell_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_status_t;

endpackage

@@ rtl/gcpm_front.sv @@
// Front end: configuration registers, item binning and classification.
// Depends on gcpm_pkg.
module gcpm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [gcpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  gcpm_pkg::cmd_t                  cmd,
  output gcpm_pkg::entry_t                entry
);
  import gcpm_pkg::*;

  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [4:0]         shift_x;
  logic [4:0]         shift_y;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        qx;
  logic [32:0]        qy;
  logic               ok_x;
  logic               ok_y;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= -32'sd8388608;
      origin_y <= -32'sd8388608;
      shift_x  <= 5'd16;
      shift_y  <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_SHIFT_X:  shift_x  <= cfg_data[4:0];
        REG_SHIFT_Y:  shift_y  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Distances are exact in 33 bits; a negative distance is out of the map.
  always_comb begin
    dx    = {cmd.point_x[31], cmd.point_x} - {origin_x[31], origin_x};
    dy    = {cmd.point_y[31], cmd.point_y} - {origin_y[31], origin_y};
    qx    = 33'(dx) >> shift_x;
    qy    = 33'(dy) >> shift_y;
    ok_x  = !dx[32] && (qx < 33'(GRID_X));
    ok_y  = !dy[32] && (qy < 33'(GRID_Y));
    rd_ok = (32'(cmd.cell_x) < 32'(GRID_X)) && (32'(cmd.cell_y) < 32'(GRID_Y));

    entry.point_x = cmd.point_x;
    entry.point_y = cmd.point_y;
    entry.op      = OP_NULL;
    entry.addr    = '0;
    case (cmd.mode)
      MODE_ADD: begin
        if (ok_x && ok_y) begin
          entry.op   = OP_ADD;
          entry.addr = ADDR_W'(qy) * ADDR_W'(GRID_X) + ADDR_W'(qx);
        end
      end
      MODE_SCAN: begin
        entry.op = OP_SCAN;
      end
      MODE_READ: begin
        if (rd_ok) begin
          entry.op   = OP_READ;
          entry.addr = ADDR_W'(cmd.cell_y) * ADDR_W'(GRID_X) + ADDR_W'(cmd.cell_x);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/gcpm_fifo.sv @@
// Two-entry queue of classified items between the front and back ends.
// Depends on gcpm_pkg.
module gcpm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gcpm_pkg::entry_t wdata,
  input  logic             pop,
  output gcpm_pkg::entry_t rdata,
  output logic             empty,
  output logic             full
);
  import gcpm_pkg::*;

  entry_t     slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign rdata = slots[rp];
  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/gcpm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the mean update.
// Depends on gcpm_pkg.
module gcpm_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [32:0]         mag,
  input  logic                neg,
  input  logic [16:0]         divisor,
  output logic                done,
  output logic signed [33:0]  quot
);
  import gcpm_pkg::*;

  logic [32:0]       acc;
  logic [16:0]       rem;
  logic [16:0]       dvs;
  logic              negr;
  logic [STEP_W-1:0] step;
  logic              run;
  logic [17:0]       trial;

  assign trial = {rem, acc[32]};
  assign quot  = negr ? -34'(acc) : 34'(acc);

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= mag;
      rem  <= '0;
      dvs  <= divisor;
      negr <= neg;
      step <= '0;
    end else if (run) begin
      step <= step + 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= 17'(trial - {1'b0, dvs});
        acc <= {acc[31:0], 1'b1};
      end else begin
        rem <= 17'(trial);
        acc <= {acc[31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && step == STEP_W'(DIV_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/gcpm_back.sv @@
// Back end: cell memory, clearing pass, scan sweep, mean update and results.
// Depends on gcpm_pkg and gcpm_div.
module gcpm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  gcpm_pkg::entry_t       head,
  input  logic                   empty,
  output gcpm_pkg::back_status_t status,
  output logic                   done,
  output gcpm_pkg::result_t      result
);
  import gcpm_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_DIV   = 6'b001000,
    S_WR    = 6'b010000,
    S_SCAN  = 6'b100000
  } state_t;

  state_t            state;
  entry_t            ent;
  logic [CNT_W-1:0]  sweep;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  cell_t             mem [NCELLS];
  cell_t             rd_cell;
  cell_t             held;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [ADDR_W-1:0] ra;
  cell_t             wd;
  cell_t             swept;

  logic              pop;
  logic              div_start;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [16:0]       dvs;
  logic              done_x;
  logic              done_y;
  logic signed [33:0] qx;
  logic signed [33:0] qy;
  cell_t             upd;

  assign pop    = (state == S_IDLE) && !empty;
  assign status = '{clearing: (state == S_CLEAR), pop: pop};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_cell <= mem[ra];
  end

  always_comb begin
    swept = rd_cell;
    if (rd_cell.prev && rd_cell.count == 16'd1) begin
      swept.mean_x = '0;
      swept.mean_y = '0;
      swept.count  = '0;
    end
    swept.prev = rd_cell.cur;
    swept.cur  = 1'b0;

    upd        = held;
    upd.mean_x = 32'(34'(held.mean_x) + qx);
    upd.mean_y = 32'(34'(held.mean_y) + qy);
    upd.count  = (held.count == COUNT_MAX) ? held.count : held.count + 16'd1;
    upd.cur    = 1'b1;

    ra = (state == S_SCAN) ? sweep[ADDR_W-1:0] : head.addr;
    we = 1'b0;
    wa = ent.addr;
    wd = upd;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = sweep[ADDR_W-1:0];
        wd = '0;
      end
      S_WR: begin
        we = 1'b1;
      end
      S_SCAN: begin
        we = pend;
        wa = pend_addr;
        wd = swept;
      end
      default: begin
      end
    endcase

    div_start = (state == S_RD) && (ent.op == OP_ADD);
    dx  = {ent.point_x[31], ent.point_x} - {rd_cell.mean_x[31], rd_cell.mean_x};
    dy  = {ent.point_y[31], ent.point_y} - {rd_cell.mean_y[31], rd_cell.mean_y};
    dvs = 17'(rd_cell.count) + 17'd1;
  end

  gcpm_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start),
    .mag(dx[32] ? -33'(dx) : 33'(dx)), .neg(dx[32]), .divisor(dvs),
    .done(done_x), .quot(qx)
  );

  gcpm_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start),
    .mag(dy[32] ? -33'(dy) : 33'(dy)), .neg(dy[32]), .divisor(dvs),
    .done(done_y), .quot(qy)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= head;
    end
    if (state == S_RD) begin
      held <= rd_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      pend      <= 1'b0;
      pend_addr <= '0;
      done      <= 1'b0;
      result    <= '0;
    end else begin
      done   <= 1'b0;
      result <= '0;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == CNT_W'(NCELLS - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_ADD, OP_READ: state <= S_RD;
              OP_SCAN: begin
                sweep <= '0;
                pend  <= 1'b0;
                state <= S_SCAN;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_RD: begin
          if (ent.op == OP_READ) begin
            done               <= 1'b1;
            result.mean_x      <= rd_cell.mean_x;
            result.mean_y      <= rd_cell.mean_y;
            result.point_count <= rd_cell.count;
            result.stable      <= (rd_cell.count >= 16'd2);
            state              <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (done_x && done_y) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          done            <= 1'b1;
          result.in_range <= 1'b1;
          state           <= S_IDLE;
        end
        S_SCAN: begin
          pend      <= (sweep < CNT_W'(NCELLS));
          pend_addr <= sweep[ADDR_W-1:0];
          sweep     <= sweep + 1'b1;
          if (sweep == CNT_W'(NCELLS)) begin
            pend  <= 1'b0;
            sweep <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/grid_cell_point_mean_map.sv @@
// Top level of the grid cell point mean map.
// Depends on gcpm_pkg, gcpm_front, gcpm_fifo and gcpm_back.
//
// The block keeps a 256 by 256 grid of cells, each with a running Q16.16 mean
// of the points binned into it and a saturating 16-bit count. An item is taken
// when start is high and busy is low; each item yields exactly one result on
// result, marked by done for one cycle, and the receiver cannot hold it off.
// After reset the cell memory is swept clear, one cell per cycle; busy stays
// high meanwhile, though configuration writes are taken at any time (cfg_ready
// is always high). A point add passes through the queue pop, the memory read,
// the 33-step divider used for the mean update and the write-back. A cell read
// gives its result after the memory read, a dropped point or an undefined mode
// on its pop without any memory access, and a scan sweeps every cell through
// the single memory read and write port before its result. A two-entry queue
// sits between the binning front end and the back end, so up to two further
// items are taken while one is being carried out; results always come back in
// order.
module grid_cell_point_mean_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  gcpm_pkg::cmd_t                  cmd,
  output logic                            done,
  output gcpm_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gcpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import gcpm_pkg::*;

  entry_t       entry;
  entry_t       head;
  logic         empty;
  logic         full;
  logic         accept;
  back_status_t status;

  // Always accepted, so user must keep block idle whenever config is written.
  assign cfg_ready = 1'b1;
  assign busy      = full || status.clearing;
  assign accept    = start && !busy;

  gcpm_front u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .entry(entry)
  );

  gcpm_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(accept), .wdata(entry),
    .pop(status.pop), .rdata(head),
    .empty(empty), .full(full)
  );

  gcpm_back u_back (
    .clk(clk), .rst(rst),
    .head(head), .empty(empty),
    .status(status), .done(done), .result(result)
  );

  // No result can appear while the memory is still being cleared.
  a_no_done_clearing: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !done)
    else $error("result during clearing pass");

  // A folded-in point reports no cell read fields.
  a_add_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.in_range) |-> (result.point_count == 16'd0 && !result.stable))
    else $error("point add result carries read fields");

  // Stable only when the reported count is two or more.
  a_stable_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.stable) |-> (result.point_count >= 16'd2))
    else $error("stable flag with count below two");

  // The queue never pops while empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    status.pop |-> !empty)
    else $error("queue popped while empty");

endmodule
